[hdl/cbm_pkg.sv]
`default_nettype none
package cbm_pkg;

   // cartridge RAM geometry
   localparam int RAM_BANKS = 4;
   localparam int RAM_PAGE  = 8192;
   localparam int RAM_DEPTH = RAM_BANKS * RAM_PAGE;
   localparam int RAM_AW    = $clog2(RAM_DEPTH);

   // register file
   localparam int CSR_AW = 3;
   localparam logic [CSR_AW-1:0] CSR_CART_TYPE = 3'd0;

   // result kinds
   localparam logic [1:0] KIND_ROM_READ  = 2'd0;
   localparam logic [1:0] KIND_RAM_READ  = 2'd1;
   localparam logic [1:0] KIND_OPEN_READ = 2'd2;
   localparam logic [1:0] KIND_WRITE     = 2'd3;

   // request kinds
   localparam logic REQ_READ  = 1'b0;
   localparam logic REQ_WRITE = 1'b1;

   localparam logic [7:0] OPEN_BUS  = 8'hFF;
   localparam logic [7:0] RAM_FILL  = 8'hFF;
   localparam logic [6:0] ROM_BANK_RESET = 7'd1;

   typedef struct packed {
      logic              rd_en;
      logic              wr_en;
      logic [RAM_AW-1:0] addr;
      logic [7:0]        wdata;
   } cbm_ram_req_type;

   function automatic logic [1:0] bank_wrap(input logic [1:0] bank);
      logic [1:0] r;
      r = 2'(32'(bank) % RAM_BANKS);
      return r;
   endfunction

endpackage
`default_nettype wire

[hdl/cartridge_bank_mapper.sv]
`default_nettype none
// Cartridge bank mapper: decodes CPU bus accesses of a handheld cartridge.
// Input channel req_*: one beat per bus access; tuser is the access type
// (read or write), tdata carries the bus address and the write byte.
// Result channel rsp_*: exactly one beat per access, in order; tuser is the
// access kind, tdata the ROM byte address and the read byte.
// Configuration port csr_*: register 0 (byte address 0) is the cartridge
// type byte; write it only while no access is in flight.
// Pipeline: an access is registered in stage s1 and then in the result register.
// One access is taken every cycle unless req_tready is held low; the single-port
// cartridge RAM does one read or one write per access, and the bank registers
// update at the accept edge, so the next access already sees them.
// Reset: bank registers return to their defaults and a clearing pass writes
// 0xFF into all RAM_BANKS*8192 RAM bytes, one byte per cycle; req_tready stays
// low for that time, csr writes still land.
// Stall: the result register and one stage behind it fill up while rsp_tready
// is low, after which req_tready drops; nothing is lost or repeated.
module cartridge_bank_mapper (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [23:0]                req_tdata,   // bus_address, write_data
   input  wire logic [0:0]                 req_tuser,   // req_type
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic [31:0]                     rsp_tdata,   // rom_address, read_data, zero pad
   output logic [1:0]                      rsp_tuser,   // access_kind
   input  wire logic                       csr_psel,
   input  wire logic                       csr_penable,
   input  wire logic                       csr_pwrite,
   input  wire logic [cbm_pkg::CSR_AW-1:0] csr_paddr,
   input  wire logic [31:0]                csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import cbm_pkg::*;

   logic [7:0]  cart_type_ff;
   logic [6:0]  rom_bank_ff, rom_bank_in;
   logic [1:0]  ram_bank_ff, ram_bank_in;
   logic        ram_en_ff, ram_en_in;
   logic        rom_mode_ff, rom_mode_in;

   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_kind_ff;
   logic [20:0] s1_rom_ff;
   logic        out_valid_ff, out_valid_in;
   logic [1:0]  out_kind_ff;
   logic [20:0] out_rom_ff;
   logic [7:0]  out_data_ff;

   logic        accept, s1_move;
   logic        is_write;
   logic [15:0] addr;
   logic [7:0]  wdata;
   logic        is_mbc1, is_mbc2;
   logic        in_ram_window;
   logic [4:0]  low_bits;
   logic [4:0]  low_fixed;
   logic [15:0] ram_index;
   logic [1:0]  kind;
   logic [20:0] rom_addr;
   logic [7:0]  s1_data;
   logic        csr_wr;

   cbm_ram_req_type ram_req;
   logic [7:0]      ram_rdata;
   logic            ram_busy;

   assign is_write = (req_tuser[0] == REQ_WRITE);
   assign addr     = req_tdata[15:0];
   assign wdata    = req_tdata[23:16];

   assign s1_move    = !out_valid_ff || rsp_tready;
   assign req_tready = !ram_busy && (!s1_valid_ff || s1_move);
   assign accept     = req_tvalid && req_tready;

   assign is_mbc1 = (cart_type_ff >= 8'h01) && (cart_type_ff <= 8'h03);
   assign is_mbc2 = (cart_type_ff == 8'h04) || (cart_type_ff == 8'h05);
   assign in_ram_window = (addr[15:13] == 3'b101);

   // a zero low field selects the next bank up
   assign low_bits  = wdata[4:0];
   assign low_fixed = (low_bits == 5'd0) ? 5'd1 : low_bits;

   assign ram_index = {bank_wrap(ram_bank_ff), 1'b0, 13'd0} >> 1 | {3'd0, addr[12:0]};

   always_comb begin
      ram_req.rd_en = accept && !is_write && in_ram_window;
      ram_req.wr_en = accept && is_write && is_mbc1 && in_ram_window && ram_en_ff;
      ram_req.addr  = ram_index[RAM_AW-1:0];
      ram_req.wdata = wdata;
   end

   cbm_ram u_ram (
      .clock     (clock),
      .reset     (reset),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .ram_busy  (ram_busy)
   );

   // bank register updates
   always_comb begin
      rom_bank_in = rom_bank_ff;
      ram_bank_in = ram_bank_ff;
      ram_en_in   = ram_en_ff;
      rom_mode_in = rom_mode_ff;
      if (accept && is_write) begin
         if (is_mbc1) begin
            unique case (addr[15:13])
               3'd0: ram_en_in = (wdata != 8'd0);
               3'd1: rom_bank_in = {rom_bank_ff[6:5], low_fixed};
               3'd2: begin
                  if (rom_mode_ff) begin
                     rom_bank_in = {wdata[1:0], rom_bank_ff[4:0]};
                  end else begin
                     ram_bank_in = wdata[1:0];
                  end
               end
               3'd3: rom_mode_in = (wdata != 8'd0);
               default: ;
            endcase
         end else if (is_mbc2) begin
            unique case (addr[15:13])
               3'd0: ram_en_in = (wdata != 8'd0);
               3'd1: rom_bank_in = {2'b00, low_fixed};
               default: ;
            endcase
         end
      end
   end

   // classify the access
   always_comb begin
      rom_addr = '0;
      if (is_write) begin
         kind = KIND_WRITE;
      end else if (addr[15:14] == 2'b00) begin
         kind     = KIND_ROM_READ;
         rom_addr = {7'd0, addr[13:0]};
      end else if (addr[15:14] == 2'b01) begin
         kind     = KIND_ROM_READ;
         rom_addr = {rom_bank_ff, addr[13:0]};
      end else if (in_ram_window) begin
         kind = KIND_RAM_READ;
      end else begin
         kind = KIND_OPEN_READ;
      end
   end

   always_comb begin
      case (s1_kind_ff)
         KIND_RAM_READ:  s1_data = ram_rdata;
         KIND_OPEN_READ: s1_data = OPEN_BUS;
         default:        s1_data = 8'd0;
      endcase
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_move) begin
         out_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cart_type_ff <= 8'd0;
         rom_bank_ff  <= ROM_BANK_RESET;
         ram_bank_ff  <= 2'd0;
         ram_en_ff    <= 1'b0;
         rom_mode_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr && (csr_paddr[CSR_AW-1:2] == CSR_CART_TYPE[CSR_AW-1:2])) begin
            cart_type_ff <= csr_pwdata[7:0];
         end
         rom_bank_ff  <= rom_bank_in;
         ram_bank_ff  <= ram_bank_in;
         ram_en_ff    <= ram_en_in;
         rom_mode_ff  <= rom_mode_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_kind_ff <= kind;
         s1_rom_ff  <= rom_addr;
      end
      if (s1_move && s1_valid_ff) begin
         out_kind_ff <= s1_kind_ff;
         out_rom_ff  <= s1_rom_ff;
         out_data_ff <= s1_data;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_kind_ff;
   assign rsp_tdata  = {3'd0, out_data_ff, out_rom_ff};

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[CSR_AW-1:2] == CSR_CART_TYPE[CSR_AW-1:2]) ?
                       {24'd0, cart_type_ff} : 32'd0;

endmodule
`default_nettype wire

[hdl/cbm_ram.sv]
`default_nettype none
module cbm_ram (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cbm_pkg::cbm_ram_req_type ram_req,
   output logic [7:0]                    ram_rdata,
   output logic                          ram_busy
);
   import cbm_pkg::*;

   logic [7:0] mem [RAM_DEPTH];

   logic              clearing_ff, clearing_in;
   logic [RAM_AW-1:0] clr_addr_ff, clr_addr_in;
   logic              wr_en;
   logic [RAM_AW-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        rdata_ff;

   // sweep every entry to the fill byte after reset
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + 1'b1;
         if (clr_addr_ff == RAM_AW'(RAM_DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   assign wr_en   = clearing_ff || ram_req.wr_en;
   assign wr_addr = clearing_ff ? clr_addr_ff : ram_req.addr;
   assign wr_data = clearing_ff ? RAM_FILL : ram_req.wdata;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rdata_ff <= mem[ram_req.addr];
      end
   end

   assign ram_rdata = rdata_ff;
   assign ram_busy  = clearing_ff;

endmodule
`default_nettype wire

[verif/cartridge_bank_mapper_tb.sv]
`timescale 1ns / 100ps

module cartridge_bank_mapper_tb;
   import cbm_pkg::*;

   localparam int WATCHDOG_LIMIT = 200000;
   localparam int SETTLE_CYCLES  = 4;
   localparam int PHASE_ITEMS    = 160;
   localparam int PHASE_COUNT    = 10;

   // cartridge type bytes
   localparam logic [7:0] TYPE_NONE      = 8'h00;
   localparam logic [7:0] TYPE_MBC1      = 8'h01;
   localparam logic [7:0] TYPE_MBC1_RAM  = 8'h02;
   localparam logic [7:0] TYPE_MBC1_BATT = 8'h03;
   localparam logic [7:0] TYPE_MBC2      = 8'h04;
   localparam logic [7:0] TYPE_MBC2_BATT = 8'h05;
   localparam logic [7:0] TYPE_MBC3      = 8'h11;
   localparam logic [7:0] TYPE_MBC3_BATT = 8'h13;
   localparam logic [7:0] TYPE_UNKNOWN   = 8'hFF;

   localparam logic [7:0] PHASE_TYPES [PHASE_COUNT] = '{
      TYPE_MBC1_BATT, TYPE_MBC2, TYPE_NONE, TYPE_MBC1_RAM, TYPE_MBC3,
      TYPE_MBC2_BATT, TYPE_UNKNOWN, TYPE_MBC1, TYPE_MBC3_BATT, TYPE_MBC1
   };

   typedef struct packed {
      logic [1:0]  kind;
      logic [20:0] rom_addr;
      logic [7:0]  rdata;
   } bus_result_type;

   class bank_mapper_model;
      bus_result_type expected_beats[$];
      logic [7:0]  cart_type;
      logic [6:0]  rom_bank;
      logic [1:0]  ram_bank;
      bit          ram_en;
      bit          upper_mode;
      logic [7:0]  ram_image [RAM_DEPTH];
      int unsigned errors;

      function new();
         cart_type  = TYPE_NONE;
         rom_bank   = ROM_BANK_RESET;
         ram_bank   = 2'd0;
         ram_en     = 1'b0;
         upper_mode = 1'b0;
         errors     = 0;
         foreach (ram_image[i]) ram_image[i] = RAM_FILL;
      endfunction

      function int ram_slot(logic [15:0] addr);
         return int'(addr[12:0]) + (int'(ram_bank) % RAM_BANKS) * RAM_PAGE;
      endfunction

      function void mbc1_write(logic [15:0] addr, logic [7:0] data);
         logic [6:0] bank;
         if (addr < 16'h2000) begin
            ram_en = (data != 8'd0);
         end else if (addr < 16'h4000) begin
            // bank numbers with all low five bits clear step up by one
            bank     = {rom_bank[6:5], data[4:0]};
            rom_bank = (bank[4:0] == 5'd0) ? bank + 7'd1 : bank;
         end else if (addr < 16'h6000) begin
            if (upper_mode) rom_bank = {data[1:0], rom_bank[4:0]};
            else ram_bank = data[1:0];
         end else if (addr < 16'h8000) begin
            upper_mode = (data != 8'd0);
         end else if (addr >= 16'hA000 && addr < 16'hC000 && ram_en) begin
            ram_image[ram_slot(addr)] = data;
         end
      endfunction

      function void note_access(logic req_kind, logic [15:0] addr, logic [7:0] data);
         bus_result_type res;
         res.kind     = KIND_WRITE;
         res.rom_addr = '0;
         res.rdata    = '0;
         if (req_kind == REQ_WRITE) begin
            if (cart_type >= TYPE_MBC1 && cart_type <= TYPE_MBC1_BATT) begin
               mbc1_write(addr, data);
            end else if (cart_type >= TYPE_MBC2 && cart_type <= TYPE_MBC2_BATT) begin
               if (addr < 16'h2000)
                  ram_en = (data != 8'd0);
               else if (addr < 16'h4000)
                  rom_bank = {2'b00, (data[4:0] == 5'd0) ? 5'd1 : data[4:0]};
            end
         end else if (addr < 16'h4000) begin
            res.kind     = KIND_ROM_READ;
            res.rom_addr = {5'd0, addr};
         end else if (addr < 16'h8000) begin
            res.kind     = KIND_ROM_READ;
            res.rom_addr = {rom_bank, addr[13:0]};
         end else if (addr >= 16'hA000 && addr < 16'hC000) begin
            // RAM reads ignore the enable bit
            res.kind  = KIND_RAM_READ;
            res.rdata = ram_image[ram_slot(addr)];
         end else begin
            res.kind  = KIND_OPEN_READ;
            res.rdata = OPEN_BUS;
         end
         expected_beats.push_back(res);
      endfunction

      function void check_beat(logic [1:0] kind, logic [20:0] rom_addr, logic [7:0] rdata);
         bus_result_type want;
         if (expected_beats.size() == 0) begin
            $error("result beat with nothing expected: access_kind %0d", kind);
            errors++;
            return;
         end
         want = expected_beats.pop_front();
         if (kind !== want.kind) begin
            $error("access_kind: expected %0d, actual %0d", want.kind, kind);
            errors++;
         end
         if (rom_addr !== want.rom_addr) begin
            $error("rom_address: expected %h, actual %h", want.rom_addr, rom_addr);
            errors++;
         end
         if (rdata !== want.rdata) begin
            $error("read_data: expected %h, actual %h", want.rdata, rdata);
            errors++;
         end
      endfunction
   endclass

   logic                clock       = 1'b0;
   logic                reset       = 1'b1;
   logic                req_tvalid  = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata   = '0;   // bus_address, write_data
   logic [0:0]          req_tuser   = '0;   // req_type
   logic                rsp_tvalid;
   logic                rsp_tready  = 1'b0;
   logic [31:0]         rsp_tdata;          // rom_address, read_data, zero pad
   logic [1:0]          rsp_tuser;          // access_kind
   logic                csr_psel    = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr   = '0;
   logic [31:0]         csr_pwdata  = '0;
   logic [31:0]         csr_prdata;
   logic                csr_pready;

   int unsigned         send_idle_pct = 0;
   int unsigned         stall_pct     = 0;
   int unsigned         quiet_cycles  = 0;
   bank_mapper_model    mapper = new();

   cartridge_bank_mapper i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         mapper.check_beat(rsp_tuser, rsp_tdata[20:0], rsp_tdata[28:21]);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // called at a falling edge, returns at a later falling edge
   task automatic issue_access(logic req_kind, logic [15:0] addr, logic [7:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= req_kind;
      req_tdata  <= {data, addr};
      do @(posedge clock); while (!req_tready);
      mapper.note_access(req_kind, addr, data);
      @(negedge clock);
   endtask

   task automatic hold_for_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (mapper.expected_beats.size() != 0);
   endtask

   task automatic set_cart_type(logic [7:0] value);
      hold_for_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_CART_TYPE;
      csr_pwdata  <= {24'd0, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      mapper.cart_type = value;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== {24'd0, value}) begin
         $error("cart_type_code: expected %h, actual %h", {24'd0, value}, csr_prdata);
         mapper.errors++;
      end
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   function automatic logic [15:0] pick_ram_addr();
      // favour a small window so reads land on bytes written earlier
      if ($urandom_range(1) == 0) return 16'hA000 + 16'($urandom_range(15));
      return 16'hA000 + 16'($urandom_range(16'h1FFF));
   endfunction

   task automatic random_access();
      logic [15:0] addr;
      logic [7:0]  data;
      logic        req_kind;
      int unsigned pick;
      pick     = $urandom_range(99);
      data     = 8'($urandom_range(255));
      req_kind = REQ_WRITE;
      if (pick < 10) begin
         addr = 16'($urandom_range(16'h1FFF));
         if ($urandom_range(3) == 0) data = 8'h00;
         else if ($urandom_range(1) == 0) data = 8'h0A;
      end else if (pick < 22) begin
         addr = 16'h2000 + 16'($urandom_range(16'h1FFF));
      end else if (pick < 30) begin
         addr = 16'h4000 + 16'($urandom_range(16'h1FFF));
      end else if (pick < 35) begin
         addr = 16'h6000 + 16'($urandom_range(16'h1FFF));
         if ($urandom_range(1) == 0) data = 8'h00;
      end else if (pick < 50) begin
         addr = pick_ram_addr();
      end else if (pick < 80) begin
         req_kind = REQ_READ;
         case ($urandom_range(2))
            0: addr = 16'($urandom_range(16'h3FFF));
            1: addr = 16'h4000 + 16'($urandom_range(16'h3FFF));
            default: addr = pick_ram_addr();
         endcase
      end else if (pick < 90) begin
         req_kind = REQ_READ;
         addr     = 16'($urandom_range(16'hFFFF));
      end else begin
         addr = 16'($urandom_range(16'hFFFF));
      end
      issue_access(req_kind, addr, data);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // no mapper: both ends of every region, writes have no effect
      issue_access(REQ_READ, 16'h0000, 8'h00);
      issue_access(REQ_READ, 16'h3FFF, 8'hFF);
      issue_access(REQ_READ, 16'h4000, 8'h00);
      issue_access(REQ_READ, 16'h7FFF, 8'h00);
      issue_access(REQ_READ, 16'h8000, 8'h00);
      issue_access(REQ_READ, 16'h9FFF, 8'h00);
      issue_access(REQ_READ, 16'hA000, 8'h00);
      issue_access(REQ_WRITE, 16'h2000, 8'h1F);
      issue_access(REQ_WRITE, 16'hA000, 8'h55);
      issue_access(REQ_READ, 16'hBFFF, 8'h00);
      issue_access(REQ_READ, 16'hC000, 8'h00);
      issue_access(REQ_READ, 16'hFFFF, 8'h00);

      set_cart_type(TYPE_MBC1);
      issue_access(REQ_WRITE, 16'h0000, 8'h0A);
      issue_access(REQ_WRITE, 16'hBFFF, 8'h5A);
      issue_access(REQ_WRITE, 16'h2000, 8'h00);
      issue_access(REQ_READ, 16'h4000, 8'h00);
      issue_access(REQ_WRITE, 16'h3FFF, 8'hFF);
      issue_access(REQ_WRITE, 16'h6000, 8'h01);
      issue_access(REQ_WRITE, 16'h4000, 8'h03);
      issue_access(REQ_READ, 16'h7FFF, 8'h00);
      issue_access(REQ_WRITE, 16'h2000, 8'h20);
      issue_access(REQ_WRITE, 16'h7FFF, 8'h00);
      issue_access(REQ_WRITE, 16'h5FFF, 8'hFF);
      issue_access(REQ_WRITE, 16'hA123, 8'hAB);
      issue_access(REQ_WRITE, 16'h1FFF, 8'h00);
      issue_access(REQ_READ, 16'hA123, 8'h00);
      issue_access(REQ_WRITE, 16'hFFFF, 8'h12);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         set_cart_type(PHASE_TYPES[p]);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 68; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 68; end
            default: begin send_idle_pct = 37; stall_pct = 37; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (p % 3 == 1 && i == PHASE_ITEMS / 2) hold_for_results();
            random_access();
         end
      end

      hold_for_results();
      repeat (8) @(posedge clock);
      if (mapper.expected_beats.size() != 0) begin
         $error("%0d expected results never arrived", mapper.expected_beats.size());
         mapper.errors++;
      end
      if (mapper.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

[sim.f]
hdl/cbm_pkg.sv
hdl/cbm_ram.sv
hdl/cartridge_bank_mapper.sv
verif/cartridge_bank_mapper_tb.sv
